/* rtl/hse_pkg.sv */
package hse_pkg;

  localparam logic [1:0] OP_KEY    = 2'd0;
  localparam logic [1:0] OP_MSG    = 2'd1;
  localparam logic [1:0] OP_FINISH = 2'd2;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_KEY  = 2'd1;
  localparam logic [1:0] PH_MSG  = 2'd2;

  localparam logic [7:0] IPAD = 8'h36;
  localparam logic [7:0] OPAD = 8'h5c;
  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned AddrW = 6;

  // byte source for the hash core
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } byte_req_t;

  function automatic logic [31:0] iv_word(input logic [2:0] idx);
    logic [31:0] r;
    begin
      unique case (idx)
        3'd0: r = 32'h67452301;
        3'd1: r = 32'hefcdab89;
        3'd2: r = 32'h98badcfe;
        3'd3: r = 32'h10325476;
        default: r = 32'hc3d2e1f0;
      endcase
      return r;
    end
  endfunction

  function automatic logic [31:0] round_k(input logic [6:0] rnd);
    logic [31:0] r;
    begin
      if (rnd < 7'd20) r = 32'h5a827999;
      else if (rnd < 7'd40) r = 32'h6ed9eba1;
      else if (rnd < 7'd60) r = 32'h8f1bbcdc;
      else r = 32'hca62c1d6;
      return r;
    end
  endfunction

  function automatic logic [31:0] round_f(input logic [6:0] rnd, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] r;
    begin
      if (rnd < 7'd20) r = (b & c) | (~b & d);
      else if (rnd < 7'd40) r = b ^ c ^ d;
      else if (rnd < 7'd60) r = (b & c) | (b & d) | (c & d);
      else r = b ^ c ^ d;
      return r;
    end
  endfunction

endpackage

/* rtl/hse_ram.sv */
module hse_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

/* rtl/hse_core.sv */
// sha-1 core: bytes go into a block ram, each full block is loaded into a 16-word window, then 80 rounds
module hse_core import hse_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        init_i,
  input  byte_req_t   req_i,
  input  logic        count_i,
  output logic        busy_o,
  output logic [60:0] total_o,
  output logic [5:0]  fill_o,
  output logic [159:0] cv_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOAD = 2'd1;
  localparam logic [1:0] S_RND  = 2'd2;
  localparam logic [1:0] S_ADD  = 2'd3;

  logic [1:0]  st_q, st_d;
  logic [5:0]  fill_q, fill_d;
  logic [60:0] tot_q, tot_d;
  logic [31:0] cv_q [5];
  logic [31:0] a_q, b_q, c_q, d_q, e_q;
  logic [6:0]  cnt_q, cnt_d;
  logic [31:0] wbuf_q [16];

  logic        bwe;
  logic [5:0]  braddr;
  logic [7:0]  brdata;

  hse_ram #(.Width(8), .Depth(BlockBytes)) u_blk (
    .clk_i, .we_i(bwe), .waddr_i(fill_q), .wdata_i(req_i.data),
    .raddr_i(braddr), .rdata_o(brdata)
  );

  assign bwe = (st_q == S_IDLE) && req_i.valid;
  assign braddr = cnt_q[5:0];
  assign busy_o = (st_q != S_IDLE);
  assign total_o = tot_q;
  assign fill_o = fill_q;
  assign cv_o = {cv_q[0], cv_q[1], cv_q[2], cv_q[3], cv_q[4]};

  logic [31:0] w_cur, f_k, t_new;
  logic [31:0] wx;
  always_comb begin
    wx = wbuf_q[13] ^ wbuf_q[8] ^ wbuf_q[2] ^ wbuf_q[0];
    w_cur = (cnt_q < 7'd16) ? wbuf_q[0] : {wx[30:0], wx[31]};
    f_k = round_f(cnt_q, b_q, c_q, d_q) + round_k(cnt_q);
    t_new = f_k + {a_q[26:0], a_q[31:27]} + e_q + w_cur;
  end

  always_comb begin
    st_d = st_q;
    fill_d = fill_q;
    tot_d = tot_q;
    cnt_d = cnt_q;
    unique case (st_q)
      S_IDLE: begin
        if (init_i) begin
          fill_d = '0;
          tot_d = '0;
        end else if (req_i.valid) begin
          fill_d = fill_q + 6'd1;
          if (count_i) tot_d = tot_q + 61'd1;
          if (fill_q == 6'd63) begin
            st_d = S_LOAD;
            cnt_d = '0;
          end
        end
      end
      // 64 byte reads from the registered ram output, shifted into the window
      S_LOAD: begin
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'd64) begin
          st_d = S_RND;
          cnt_d = '0;
        end
      end
      S_RND: begin
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'd79) st_d = S_ADD;
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      fill_q <= '0;
      tot_q <= '0;
      cnt_q <= '0;
      for (int i = 0; i < 5; i++) cv_q[i] <= iv_word(3'(i));
    end else begin
      st_q <= st_d;
      fill_q <= fill_d;
      tot_q <= tot_d;
      cnt_q <= cnt_d;
      if (st_q == S_IDLE && init_i) begin
        for (int i = 0; i < 5; i++) cv_q[i] <= iv_word(3'(i));
      end
      if (st_q == S_ADD) begin
        cv_q[0] <= cv_q[0] + a_q;
        cv_q[1] <= cv_q[1] + b_q;
        cv_q[2] <= cv_q[2] + c_q;
        cv_q[3] <= cv_q[3] + d_q;
        cv_q[4] <= cv_q[4] + e_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == S_LOAD) begin
      if (cnt_q != 7'd0) begin
        wbuf_q[15][7:0] <= brdata;
        wbuf_q[15][31:8] <= wbuf_q[15][23:0];
        // a finished word moves down when the first byte of the next one arrives
        if (cnt_q[1:0] == 2'd1 && cnt_q != 7'd1) begin
          for (int i = 0; i < 15; i++) wbuf_q[i] <= wbuf_q[i+1];
        end
      end
      a_q <= cv_q[0]; b_q <= cv_q[1]; c_q <= cv_q[2]; d_q <= cv_q[3]; e_q <= cv_q[4];
    end else if (st_q == S_RND) begin
      for (int i = 0; i < 15; i++) wbuf_q[i] <= wbuf_q[i+1];
      wbuf_q[15] <= w_cur;
      e_q <= d_q;
      d_q <= c_q;
      c_q <= {b_q[1:0], b_q[31:2]};
      b_q <= a_q;
      a_q <= t_new;
    end
  end

endmodule

/* rtl/hmac_sha1_engine_unit.sv */
// hmac/sha-1 engine, one input word per key byte, message byte or finish. a key or message
// byte is taken while the engine is idle; a byte that closes a 64 byte block holds the input
// off while the core reads the block from its ram, runs 80 rounds and adds. key bytes past
// the stored count read as zero, so a new key needs no clearing. in hmac mode a message
// start first streams the 64 key^0x36 bytes; a key longer than 64 bytes is first padded
// and its 20 byte digest written back. a finish pads at one byte per cycle while the core
// is free (9 to 72 bytes, one or two blocks), in hmac mode adds the key^0x5c block, 20
// inner digest bytes and the outer padding, then five digest words leave in order at the
// pace of m_axis_tready. input and config wait while any of this runs.
module hmac_sha1_engine_unit import hse_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte[7:0]
  input  logic [1:0]  s_axis_tuser,   // operation[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // digest_word[31:0], word_index[34:32], zero fill
  output logic        m_axis_tlast,   // last_word
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i      // hmac_enable
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_KHASH  = 4'd1;  // stream 64 key bytes into core
  localparam logic [3:0] S_IPAD   = 4'd2;
  localparam logic [3:0] S_OPAD   = 4'd3;
  localparam logic [3:0] S_PAD    = 4'd4;  // final padding bytes
  localparam logic [3:0] S_KDIG   = 4'd5;  // write long-key digest to key ram
  localparam logic [3:0] S_IDIG   = 4'd6;  // absorb inner digest bytes
  localparam logic [3:0] S_IDONE  = 4'd7;  // inner digest ready
  localparam logic [3:0] S_OUT    = 4'd8;
  localparam logic [3:0] S_WAIT   = 4'd9;  // core busy, resume
  localparam logic [3:0] S_MSG1   = 4'd10; // absorb pending byte or start padding

  // what happens after padding completes
  localparam logic [1:0] F_KEY   = 2'd0;
  localparam logic [1:0] F_INNER = 2'd1;
  localparam logic [1:0] F_OUTER = 2'd2;

  logic [3:0]  st_q, st_d, ret_q, ret_d;
  logic [1:0]  ph_q, ph_d;
  logic [1:0]  fin_q, fin_d;
  logic        fpend_q, fpend_d;  // pending word is a finish
  logic        hen_q;
  logic [6:0]  kcnt_q, kcnt_d;
  logic [6:0]  idx_q, idx_d;
  logic [7:0]  pend_q, pend_d;
  logic [159:0] idig_q;
  logic [2:0]  oidx_q, oidx_d;

  logic [1:0]  op;
  logic [7:0]  din;
  logic        acc;

  byte_req_t   req;
  logic        cinit, ccount, cbusy;
  logic [60:0] ctot;
  logic [5:0]  cfill;
  logic [159:0] ccv;

  logic             kwe;
  logic [AddrW-1:0] kwaddr, kraddr;
  logic [7:0]       kwdata, krdata;

  hse_ram #(.Width(8), .Depth(BlockBytes)) u_key (
    .clk_i, .we_i(kwe), .waddr_i(kwaddr), .wdata_i(kwdata),
    .raddr_i(kraddr), .rdata_o(krdata)
  );

  hse_core u_core (
    .clk_i, .rst_ni, .init_i(cinit), .req_i(req), .count_i(ccount),
    .busy_o(cbusy), .total_o(ctot), .fill_o(cfill), .cv_o(ccv)
  );

  assign op = s_axis_tuser;
  assign din = s_axis_tdata;
  assign s_axis_tready = (st_q == S_IDLE) && !cbusy;
  assign acc = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o = (st_q == S_IDLE) && !cbusy;
  assign m_axis_tvalid = (st_q == S_OUT);
  assign m_axis_tdata = {5'd0, oidx_q, ccv[(8'd128 - {oidx_q, 5'b00000}) +: 32]};
  assign m_axis_tlast = (oidx_q == 3'd4);

  logic [63:0] bits;
  logic [7:0]  lenb, idb, kdb, kb;
  assign bits = {ctot, 3'd0};
  // length bytes sit at fill 56..63, most significant first
  assign lenb = bits[{~cfill[2:0], 3'b000} +: 8];
  assign idb = idig_q[(8'd152 - {idx_q[4:0], 3'b000}) +: 8];
  assign kdb = ccv[(8'd152 - {idx_q[4:0], 3'b000}) +: 8];
  // key ram data lags idx by one; bytes past the key length are zero
  assign kb = (idx_q <= kcnt_q) ? krdata : 8'd0;

  always_comb begin
    st_d = st_q; ret_d = ret_q; ph_d = ph_q; fin_d = fin_q; fpend_d = fpend_q;
    kcnt_d = kcnt_q; idx_d = idx_q; pend_d = pend_q; oidx_d = oidx_q;
    req = '0; cinit = 1'b0; ccount = 1'b1;
    kwe = 1'b0; kwaddr = idx_q[AddrW-1:0]; kwdata = 8'd0; kraddr = idx_q[AddrW-1:0];
    unique case (st_q)
      S_IDLE: begin
        if (acc) begin
          unique case (op)
            OP_KEY: begin
              if (hen_q) begin
                if (ph_q != PH_KEY) begin
                  ph_d = PH_KEY; kwe = 1'b1; kwaddr = '0; kwdata = din; kcnt_d = 7'd1;
                end else if (kcnt_q < 7'd64) begin
                  kwe = 1'b1; kwaddr = kcnt_q[AddrW-1:0]; kwdata = din;
                  kcnt_d = kcnt_q + 7'd1;
                end else if (kcnt_q == 7'd64) begin
                  pend_d = din; fpend_d = 1'b0; kcnt_d = 7'd65; idx_d = '0;
                  st_d = S_KHASH;
                end else begin
                  req.valid = 1'b1; req.data = din;
                end
              end
            end
            OP_MSG, OP_FINISH: begin
              pend_d = din;
              fpend_d = (op == OP_FINISH);
              if (ph_q != PH_MSG) begin
                ph_d = PH_MSG; idx_d = '0;
                if (ph_q == PH_KEY && kcnt_q == 7'd65) begin
                  fin_d = F_KEY; st_d = S_PAD;
                end else if (hen_q) begin
                  st_d = S_IPAD;
                end else begin
                  cinit = 1'b1; st_d = S_MSG1;
                end
              end else if (op == OP_MSG) begin
                req.valid = 1'b1; req.data = din;
              end else begin
                fin_d = F_INNER; idx_d = '0; st_d = S_PAD;
              end
            end
            default: ;
          endcase
        end
      end
      // the core is idle on entry; idx 0 restarts it, idx 1..64 feed key bytes 0..63
      S_KHASH, S_IPAD, S_OPAD: begin
        if (idx_q == 7'd0) begin
          cinit = 1'b1; idx_d = 7'd1;
        end else begin
          req.valid = 1'b1;
          req.data = (st_q == S_IPAD) ? (kb ^ IPAD) :
                     (st_q == S_OPAD) ? (kb ^ OPAD) : kb;
          idx_d = idx_q + 7'd1;
          if (idx_q == 7'd64) begin
            idx_d = '0; st_d = S_WAIT;
            ret_d = (st_q == S_OPAD) ? S_IDIG : S_MSG1;
          end
        end
      end
      S_MSG1: begin
        if (!cbusy) begin
          if (fpend_q) begin
            idx_d = '0; fin_d = F_INNER; st_d = S_PAD;
          end else begin
            req.valid = 1'b1; req.data = pend_q; st_d = S_IDLE;
          end
        end
      end
      S_PAD: begin
        if (!cbusy) begin
          req.valid = 1'b1; ccount = 1'b0;
          if (idx_q == 7'd0) begin
            req.data = PAD_BYTE; idx_d = 7'd1;
          end else if (idx_q == 7'd1 && cfill != 6'd56) begin
            req.data = 8'd0;
          end else begin
            req.data = lenb; idx_d = 7'd2;
            if (cfill == 6'd63) begin
              st_d = S_WAIT; idx_d = '0; oidx_d = '0;
              unique case (fin_q)
                F_KEY: ret_d = S_KDIG;
                F_INNER: ret_d = S_IDONE;
                default: ret_d = S_OUT;
              endcase
            end
          end
        end
      end
      S_WAIT: begin
        if (!cbusy) st_d = ret_q;
      end
      S_KDIG: begin
        kwe = 1'b1; kwdata = kdb;
        idx_d = idx_q + 7'd1;
        if (idx_q == 7'd19) begin
          kcnt_d = 7'd20; idx_d = '0;
          if (hen_q) begin
            st_d = S_IPAD;
          end else begin
            cinit = 1'b1; st_d = S_MSG1;
          end
        end
      end
      S_IDONE: begin
        oidx_d = '0;
        if (hen_q) begin
          idx_d = '0; fin_d = F_OUTER; st_d = S_OPAD;
        end else begin
          st_d = S_OUT;
        end
      end
      S_IDIG: begin
        if (!cbusy) begin
          req.valid = 1'b1; req.data = idb;
          idx_d = idx_q + 7'd1;
          if (idx_q == 7'd19) begin
            idx_d = '0; fin_d = F_OUTER; st_d = S_PAD;
          end
        end
      end
      S_OUT: begin
        if (m_axis_tready) begin
          oidx_d = oidx_q + 3'd1;
          if (oidx_q == 3'd4) begin
            st_d = S_IDLE; ph_d = PH_IDLE;
          end
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; ret_q <= S_IDLE; ph_q <= PH_IDLE; fin_q <= F_INNER;
      fpend_q <= 1'b0; hen_q <= 1'b0; kcnt_q <= '0; idx_q <= '0; oidx_q <= '0;
    end else begin
      st_q <= st_d; ret_q <= ret_d; ph_q <= ph_d; fin_q <= fin_d;
      fpend_q <= fpend_d; kcnt_q <= kcnt_d; idx_q <= idx_d; oidx_q <= oidx_d;
      if (cfg_valid_i && cfg_ready_o) hen_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    if (st_q == S_IDONE) idig_q <= ccv;
  end

endmodule

/* rtl/hse_checker.sv */
module hse_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word dropped while stalled");

  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[34:32] == 3'd4)))
    else $error("tlast mismatch");

  a_noin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input taken during digest output");

  a_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
      m_axis_tvalid && m_axis_tdata[34:32] == $past(m_axis_tdata[34:32]) + 3'd1)
    else $error("digest words out of order");

endmodule

bind hmac_sha1_engine_unit hse_checker u_hse_checker (.*);

/* tb/hmac_sha1_engine_unit_test.sv */
module hmac_sha1_engine_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import hse_pkg::*;

  localparam int WatchdogLimit = 40000;

  class digest_scoreboard;
    logic        hmac_on;
    logic [31:0] cv[5];
    logic [7:0]  blk[64];
    int unsigned fill;
    logic [60:0] total;
    logic [7:0]  key[64];
    int unsigned key_cnt;
    logic [1:0]  ph;
    logic [31:0] want_word[$];
    logic [2:0]  want_idx[$];
    int          errors;
    int          words_seen;

    function new();
      int i;
      hmac_on = 1'b0;
      for (i = 0; i < 5; i++) cv[i] = iv_word(i[2:0]);
      for (i = 0; i < 64; i++) begin
        key[i] = 8'h00;
        blk[i] = 8'h00;
      end
      fill = 0;
      total = '0;
      key_cnt = 0;
      ph = PH_IDLE;
      errors = 0;
      words_seen = 0;
    endfunction

    function void compress_block();
      logic [31:0] w[16];
      logic [31:0] a, b, c, d, e, f, k, t, x;
      int i;
      for (i = 0; i < 16; i++) w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
      a = cv[0]; b = cv[1]; c = cv[2]; d = cv[3]; e = cv[4];
      for (i = 0; i < 80; i++) begin
        if (i >= 16) begin
          x = w[(i-3)&15] ^ w[(i-8)&15] ^ w[(i-14)&15] ^ w[i&15];
          w[i&15] = {x[30:0], x[31]};
        end
        if (i < 20) begin
          f = (b & c) | (~b & d); k = 32'h5a827999;
        end else if (i < 40) begin
          f = b ^ c ^ d; k = 32'h6ed9eba1;
        end else if (i < 60) begin
          f = (b & c) | (b & d) | (c & d); k = 32'h8f1bbcdc;
        end else begin
          f = b ^ c ^ d; k = 32'hca62c1d6;
        end
        t = f + k + {a[26:0], a[31:27]} + e + w[i&15];
        e = d; d = c; c = {b[1:0], b[31:2]}; b = a; a = t;
      end
      cv[0] += a; cv[1] += b; cv[2] += c; cv[3] += d; cv[4] += e;
    endfunction

    function void put_byte(logic [7:0] v);
      blk[fill] = v;
      fill++;
      if (fill == 64) begin
        compress_block();
        fill = 0;
      end
    endfunction

    function void absorb(logic [7:0] v);
      put_byte(v);
      total = total + 61'd1;
    endfunction

    function void restart();
      int i;
      for (i = 0; i < 5; i++) cv[i] = iv_word(i[2:0]);
      fill = 0;
      total = '0;
    endfunction

    function void finalize(output logic [31:0] dg[5]);
      logic [63:0] bits;
      int i;
      bits = {total, 3'b000};
      put_byte(PAD_BYTE);
      while (fill != 56) put_byte(8'h00);
      for (i = 0; i < 8; i++) put_byte(bits[63-8*i -: 8]);
      for (i = 0; i < 5; i++) dg[i] = cv[i];
    endfunction

    function void open_message();
      logic [31:0] kd[5];
      int i;
      if (ph == PH_KEY && key_cnt >= 65) begin
        finalize(kd);
        for (i = 0; i < 64; i++) key[i] = 8'h00;
        for (i = 0; i < 20; i++) key[i] = kd[i/4][31-8*(i%4) -: 8];
        key_cnt = 20;
      end
      restart();
      if (hmac_on) for (i = 0; i < 64; i++) absorb(key[i] ^ IPAD);
      ph = PH_MSG;
    endfunction

    function void note_input(logic [1:0] op, logic [7:0] v);
      logic [31:0] inner[5];
      logic [31:0] dg[5];
      int i;
      if (op == OP_KEY) begin
        if (!hmac_on) return;
        if (ph != PH_KEY) begin
          for (i = 0; i < 64; i++) key[i] = 8'h00;
          key_cnt = 0;
          ph = PH_KEY;
        end
        if (key_cnt < 64) begin
          key[key_cnt] = v;
          key_cnt++;
        end else if (key_cnt == 64) begin
          restart();
          for (i = 0; i < 64; i++) absorb(key[i]);
          absorb(v);
          key_cnt = 65;
        end else begin
          absorb(v);
        end
      end else if (op == OP_MSG) begin
        if (ph != PH_MSG) open_message();
        absorb(v);
      end else if (op == OP_FINISH) begin
        if (ph != PH_MSG) open_message();
        finalize(inner);
        if (hmac_on) begin
          restart();
          for (i = 0; i < 64; i++) absorb(key[i] ^ OPAD);
          for (i = 0; i < 20; i++) absorb(inner[i/4][31-8*(i%4) -: 8]);
          finalize(dg);
        end else begin
          dg = inner;
        end
        ph = PH_IDLE;
        for (i = 0; i < 5; i++) begin
          want_word.push_back(dg[i]);
          want_idx.push_back(i[2:0]);
        end
      end
    endfunction

    task report_mismatch(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_word(logic [39:0] data, logic last);
      logic [31:0] w;
      logic [2:0]  idx;
      words_seen++;
      if (want_word.size() == 0) begin
        report_mismatch($sformatf("unexpected word %h", data));
        return;
      end
      w = want_word.pop_front();
      idx = want_idx.pop_front();
      if (data[31:0] !== w)
        report_mismatch($sformatf("digest word %0d: got %h want %h", idx, data[31:0], w));
      if (data[34:32] !== idx)
        report_mismatch($sformatf("word index: got %0d want %0d", data[34:32], idx));
      if (data[39:35] !== 5'd0)
        report_mismatch($sformatf("fill bits not zero: %h", data[39:35]));
      if (last !== (idx == 3'd4))
        report_mismatch($sformatf("tlast on word %0d: got %b", idx, last));
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_data_i = 1'b0;

  digest_scoreboard digests = new();
  int  idle_cycles = 0;
  int  items_sent = 0;
  bit  sink_on = 1'b1;

  hmac_sha1_engine_unit dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // watchdog on cycles with no handshake
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("watchdog expired");
      $display("TEST FAILED");
      $finish;
    end
  end

  // result side with random stalls
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      gap = sink_on ? $urandom_range(0, 5) : 0;
      m_axis_tready <= 1'b0;
      repeat (gap) @(negedge clk_i);
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      digests.check_word(m_axis_tdata, m_axis_tlast);
    end
  end

  // valid stays up after a word when the next one follows with no gap
  task automatic send_word(logic [1:0] op, logic [7:0] v, bit paced = 1'b1);
    int gap;
    gap = paced ? $urandom_range(0, 5) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= v;
    s_axis_tuser <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    digests.note_input(op, v);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (digests.want_word.size() != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
  endtask

  task automatic set_mode(logic on);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= on;
    do @(posedge clk_i); while (!cfg_ready_o);
    digests.hmac_on = on;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_message(int max_len, bit paced);
    int n;
    n = $urandom_range(0, max_len);
    repeat (n) send_word(OP_MSG, 8'($urandom_range(0, 255)), paced);
    send_word(OP_FINISH, 8'($urandom_range(0, 255)), paced);
  endtask

  initial begin
    int i, r, phase_no;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // plain mode: empty message, bytes at extremes, ignored key and unused code
    send_word(OP_FINISH, 8'h00);
    send_word(OP_KEY, 8'hff);
    send_word(OP_MSG, 8'h00);
    send_word(OP_MSG, 8'hff);
    send_word(2'd3, 8'haa);
    send_word(OP_FINISH, 8'hff);
    set_mode(1'b1);
    // short key, then finish with no message, then a one-byte message
    send_word(OP_KEY, 8'h55);
    send_word(OP_KEY, 8'haa);
    send_word(OP_FINISH, 8'h00);
    send_word(OP_MSG, 8'h80);
    send_word(OP_FINISH, 8'h00);
    // key while a message is in flight abandons it
    send_word(OP_MSG, 8'h01);
    send_word(OP_KEY, 8'h7f);
    send_word(OP_MSG, 8'hfe);
    send_word(OP_FINISH, 8'h00);
    // the sender holds off until every digest word is back
    drain();
    // long key, replaced by its hash at message start
    for (i = 0; i < 70; i++) send_word(OP_KEY, 8'($urandom_range(0, 255)), 1'b0);
    send_word(OP_MSG, 8'h3c);
    send_word(OP_FINISH, 8'h00);
    // exactly 64 key bytes
    for (i = 0; i < 64; i++) send_word(OP_KEY, 8'($urandom_range(0, 255)), 1'b0);
    send_word(OP_FINISH, 8'h00);
    // long key with plain mode at message start
    for (i = 0; i < 66; i++) send_word(OP_KEY, 8'($urandom_range(0, 255)), 1'b0);
    set_mode(1'b0);
    send_word(OP_FINISH, 8'h00);
    set_mode(1'b1);

    // random phases alternating mode, mostly whole messages
    for (phase_no = 0; phase_no < 8; phase_no++) begin
      set_mode(phase_no[0]);
      sink_on = (phase_no != 5);
      for (i = 0; i < 3; i++) begin
        r = $urandom_range(0, 9);
        if (r < 2) begin
          repeat ($urandom_range(1, 20)) send_word(OP_KEY, 8'($urandom_range(0, 255)));
        end else if (r == 2) begin
          send_word(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        end
        random_message((r == 3) ? 64 : 12, phase_no != 2);
      end
    end
    sink_on = 1'b1;

    drain();
    $display("sent %0d input words, checked %0d digest words", items_sent, digests.words_seen);
    $display("covered plain and keyed modes, short, exact and hashed keys, empty messages");
    if (digests.errors == 0 && digests.want_word.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
